// ===== rtl/fixed_point_mac_norm_relu_core_defines.svh =====
// Assertion macros shared by the MAC, normalization and ReLU core.
`ifndef FIXED_POINT_MAC_NORM_RELU_CORE_DEFINES_SVH
`define FIXED_POINT_MAC_NORM_RELU_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define FPMNR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`define FPMNR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define FPMNR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define FPMNR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/fpmnr_pkg.sv =====
// Shared types and constants for the MAC, normalization and ReLU core.
package fpmnr_pkg;

	localparam int DATA_W = 32;
	localparam int OUT_W = 31;
	localparam int IDX_W = 1;

	localparam logic [IDX_W-1:0] REG_SAT_HIGH = 1'b0;
	localparam logic [IDX_W-1:0] REG_SAT_LOW = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_NORM,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic mul;
		logic acc;
		logic norm;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic std_zero;
		logic div_busy;
	} status_t;

endpackage

// ===== rtl/fixed_point_mac_norm_relu_core.sv =====
// After a term without the last mark, the core steps through multiply and accumulate and
// returns to idle to accept the next transaction. A last term then goes through normalize,
// the bit-serial divider that resolves one of 33 + FRAC_BITS quotient bits a cycle (skipped
// for zero std) and done. Input is taken only in idle, so each term finishes before the next.
// The output register lets the next transaction start while a result waits.
// Reset (arst_n low) clears the accumulator, restores the clamp bounds and empties the output.
`include "fixed_point_mac_norm_relu_core_defines.svh"

module fixed_point_mac_norm_relu_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// activation, weight, bias_value, mean_value, std_value
	input  logic [5*fpmnr_pkg::DATA_W-1:0]   s_tdata,
	// first_term
	input  logic [0:0]                       s_tuser,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// activation_out, one zero pad bit
	output logic [fpmnr_pkg::DATA_W-1:0]     m_tdata,
	// divide_error
	output logic [0:0]                       m_tuser,
	input  logic                             cfg_we,
	input  logic [fpmnr_pkg::IDX_W-1:0]      cfg_index,
	input  logic [fpmnr_pkg::DATA_W-1:0]     cfg_data
);
	import fpmnr_pkg::*;

	cmd_t             cmd;
	status_t          status;
	logic [OUT_W-1:0] act_out;
	logic             div_err;

	fpmnr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.out_valid(m_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	fpmnr_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (s_tdata),
		.in_first (s_tuser[0]),
		.in_last  (s_tlast),
		.act_out  (act_out),
		.div_err  (div_err)
	);

	assign m_tdata = {1'b0, act_out};
	assign m_tuser = div_err;

	`FPMNR_ASSERT_SAME(a_no_accept_while_dividing, clk, arst_n, s_tready, !status.div_busy)
	`FPMNR_ASSERT_SAME(a_no_result_overwrite, clk, arst_n, cmd.load_out, !m_tvalid || m_tready)
	`FPMNR_ASSERT_SAME(a_error_forces_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == '0)
	`FPMNR_ASSERT_NEXT(a_load_out_sets_valid, clk, arst_n, cmd.load_out, m_tvalid)

endmodule

// ===== rtl/fpmnr_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
module fpmnr_div #(
	parameter int DVD_W = 49
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [DVD_W-1:0]                dividend,
	input  logic [fpmnr_pkg::DATA_W-1:0]    divisor,
	output logic                            busy,
	output logic [fpmnr_pkg::DATA_W-1:0]    quotient
);
	import fpmnr_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]  dvd_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quot_q;
	logic [DATA_W-1:0] dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff = trial - {1'b0, dsr_q};
	assign ge = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DVD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_q << 1;
			rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			quot_q <= {quot_q[DATA_W-2:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign quotient = quot_q;

endmodule

// ===== rtl/fpmnr_dp.sv =====
// Datapath: item capture, multiply, saturating accumulate, normalize and ReLU.
module fpmnr_dp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fpmnr_pkg::cmd_t                  cmd,
	output fpmnr_pkg::status_t               status,
	input  logic                             cfg_we,
	input  logic [fpmnr_pkg::IDX_W-1:0]      cfg_index,
	input  logic [fpmnr_pkg::DATA_W-1:0]     cfg_data,
	input  logic [5*fpmnr_pkg::DATA_W-1:0]   in_data,
	input  logic                             in_first,
	input  logic                             in_last,
	output logic [fpmnr_pkg::OUT_W-1:0]      act_out,
	output logic                             div_err
);
	import fpmnr_pkg::*;

	localparam int DVD_W = DATA_W + 1 + FRAC_BITS;
	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W = PROD_W + 1;

	logic signed [DATA_W-1:0] sat_high_q;
	logic signed [DATA_W-1:0] sat_low_q;
	logic signed [DATA_W-1:0] acc_q;
	logic signed [DATA_W-1:0] act_q;
	logic signed [DATA_W-1:0] wgt_q;
	logic signed [DATA_W-1:0] bias_q;
	logic signed [DATA_W-1:0] mean_q;
	logic signed [DATA_W-1:0] std_q;
	logic                     first_q;
	logic                     last_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     neg_q;
	logic                     err_q;
	logic [OUT_W-1:0]         act_out_q;
	logic                     err_out_q;

	logic signed [PROD_W-1:0] prod_sh;
	logic signed [DATA_W-1:0] base;
	logic signed [SUM_W-1:0]  sum;
	logic signed [DATA_W-1:0] clamped;
	logic signed [DATA_W:0]   diff;
	logic [DATA_W:0]          diff_mag;
	logic [DATA_W-1:0]        std_mag;
	logic [DVD_W-1:0]         dividend;
	logic                     div_busy;
	logic [DATA_W-1:0]        quot;
	logic [DATA_W-1:0]        quot_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_high_q <= {1'b0, {(DATA_W-1){1'b1}}};
			sat_low_q <= {1'b1, {(DATA_W-1){1'b0}}};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAT_HIGH: sat_high_q <= cfg_data;
				REG_SAT_LOW:  sat_low_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q <= in_data[0*DATA_W +: DATA_W];
			wgt_q <= in_data[1*DATA_W +: DATA_W];
			bias_q <= in_data[2*DATA_W +: DATA_W];
			mean_q <= in_data[3*DATA_W +: DATA_W];
			std_q <= in_data[4*DATA_W +: DATA_W];
			first_q <= in_first;
			last_q <= in_last;
		end
		if (cmd.mul) begin
			prod_q <= act_q * wgt_q;
		end
	end

	assign prod_sh = prod_q >>> FRAC_BITS;
	assign base = first_q ? bias_q : acc_q;
	assign sum = SUM_W'(prod_sh) + SUM_W'(base);

	always_comb begin
		if (sum > SUM_W'(sat_high_q)) begin
			clamped = sat_high_q;
		end else if (sum < SUM_W'(sat_low_q)) begin
			clamped = sat_low_q;
		end else begin
			clamped = sum[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.acc) begin
			acc_q <= clamped;
		end
	end

	assign diff = (DATA_W+1)'(acc_q) - (DATA_W+1)'(mean_q);
	assign diff_mag = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;
	assign std_mag = std_q[DATA_W-1] ? DATA_W'(-std_q) : std_q;
	assign dividend = DVD_W'(diff_mag) << FRAC_BITS;

	always_ff @(posedge clk) begin
		if (cmd.norm) begin
			neg_q <= diff[DATA_W] ^ std_q[DATA_W-1];
			err_q <= std_q == '0;
		end
	end

	fpmnr_div #(
		.DVD_W(DVD_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.norm && (std_q != '0)),
		.dividend(dividend),
		.divisor (std_mag),
		.busy    (div_busy),
		.quotient(quot)
	);

	assign quot_s = neg_q ? DATA_W'(-quot) : quot;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			err_out_q <= err_q;
			if (err_q || quot_s[DATA_W-1]) begin
				act_out_q <= '0;
			end else begin
				act_out_q <= quot_s[OUT_W-1:0];
			end
		end
	end

	assign status.last = last_q;
	assign status.std_zero = std_q == '0;
	assign status.div_busy = div_busy;
	assign act_out = act_out_q;
	assign div_err = err_out_q;

endmodule

// ===== rtl/fpmnr_ctrl.sv =====
// Controller state machine that sequences each transaction through the datapath.
module fpmnr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic                 m_tready,
	output logic                 out_valid,
	input  fpmnr_pkg::status_t   status,
	output fpmnr_pkg::cmd_t      cmd
);
	import fpmnr_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = status.last ? ST_NORM : ST_IDLE;
			end
			ST_NORM: begin
				cmd.norm = 1'b1;
				state_d = status.std_zero ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (!status.div_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
